// ===== design/fts_pkg.sv =====
// Shared widths, reset values and register indexes for the frame time smoother.
package fts_pkg;

    localparam int TimeW     = 64;
    localparam int PeriodW   = 20;
    localparam int DeltaW    = 23;
    localparam int CfgIdxW   = 1;

    // History ring: depth is a power of two so the average is a shift
    localparam int HistDepth = 4;
    localparam int HistIdxW  = $clog2(HistDepth);
    localparam int SumW      = DeltaW + HistIdxW;

    // Snap points are the first SnapCount multiples of the target period
    localparam int SnapCount = 8;
    localparam int PointW    = PeriodW + $clog2(SnapCount + 1);

    // A delta above 2**CapShift periods is replaced by one period
    localparam int CapShift  = 3;

    localparam logic [PeriodW-1:0] ResetPeriod    = PeriodW'(16666);
    localparam logic [PeriodW-1:0] ResetTolerance = PeriodW'(200);
    localparam logic [SumW-1:0]    ResetSum       = SumW'(HistDepth) * SumW'(ResetPeriod);

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] RegTargetPeriod  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegSnapTolerance = CfgIdxW'(1);

endpackage

// ===== design/frame_time_smoother.sv =====
// Frame delta smoother: clamp, snap to period multiples, ring average, elapsed total.
//
// Each transaction on the input carries one microsecond timestamp; every
// timestamp after the first one gives one result transaction. The block
// takes a new timestamp in every cycle: three registered stages (delta,
// clamp and snap, ring average) pass items along and only stall when the
// output register is held by out_stall. The first timestamp after reset
// only primes the previous-time register and gives no result. The history
// ring resets to four entries of 16666 us and is kept together with a
// running sum, so the average costs a subtract, two adds and a shift.
// Write target_period_us and snap_tolerance_us only while no item is in flight.
module frame_time_smoother (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_write_en,
    input  logic [fts_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [fts_pkg::PeriodW-1:0]   cfg_data,
    // timestamp channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fts_pkg::TimeW-1:0]     now_us,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fts_pkg::DeltaW-1:0]    smoothed_delta_us,
    output logic [fts_pkg::TimeW-1:0]     elapsed_us
);
    import fts_pkg::*;

    // configuration
    logic [PeriodW-1:0]  period_reg;
    logic [PeriodW-1:0]  tol_reg;

    // front end
    logic                primed_reg;
    logic [TimeW-1:0]    last_time_reg;
    logic [TimeW-1:0]    diff_next;
    logic [TimeW-1:0]    diff_reg;
    logic                s1_valid_reg;

    // clamp and snap
    logic [DeltaW-1:0]   cap;
    logic                diff_neg;
    logic                diff_over;
    logic [DeltaW-1:0]   clamped;
    logic [PointW-1:0]   snap_point [SnapCount];
    logic [PointW-1:0]   snap_dist  [SnapCount];
    logic                snap_hit   [SnapCount];
    logic [DeltaW-1:0]   snap_next;
    logic [DeltaW-1:0]   snap_reg;
    logic                s2_valid_reg;

    // ring average
    logic [DeltaW-1:0]   hist_reg [HistDepth];
    logic [HistIdxW-1:0] head_reg;
    logic [SumW-1:0]     sum_reg;
    logic [SumW-1:0]     sum_next;
    logic [HistIdxW-1:0] resid_reg;
    logic [SumW-1:0]     avg_total;
    logic [DeltaW-1:0]   avg_next;
    logic [TimeW-1:0]    elapsed_reg;
    logic [TimeW-1:0]    elapsed_next;
    logic [DeltaW-1:0]   smooth_reg;
    logic                out_valid_reg;

    // handshake
    logic                out_ready;
    logic                s2_ready;
    logic                s1_ready;
    logic                in_accept;
    logic                s1_move;
    logic                s2_move;

    // Advance each stage when the next one is empty or moving on
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_accept = in_valid && s1_ready;
    assign s1_move   = s1_valid_reg && s2_ready;
    assign s2_move   = s2_valid_reg && out_ready;

    assign in_stall          = !s1_ready;
    assign out_valid         = out_valid_reg;
    assign smoothed_delta_us = smooth_reg;
    assign elapsed_us        = elapsed_reg;

    // Raw wrapping delta against the previous timestamp
    assign diff_next = now_us - last_time_reg;

    // Clamp: negative to zero, above eight periods to one period
    assign cap       = DeltaW'(period_reg) << CapShift;
    assign diff_neg  = diff_reg[TimeW-1];
    assign diff_over = (|diff_reg[TimeW-2:DeltaW]) || (diff_reg[DeltaW-1:0] > cap);
    assign clamped   = diff_neg  ? '0 :
                       diff_over ? DeltaW'(period_reg) : diff_reg[DeltaW-1:0];

    // Compare against every snap point in parallel
    always_comb
    begin
        for (int k = 0; k < SnapCount; k++)
        begin
            snap_point[k] = PointW'(period_reg) * PointW'(k + 1);
            snap_dist[k]  = (PointW'(clamped) >= snap_point[k]) ?
                            PointW'(clamped) - snap_point[k] :
                            snap_point[k] - PointW'(clamped);
            snap_hit[k]   = snap_dist[k] < PointW'(tol_reg);
        end
    end

    // Pick the lowest matching multiple
    always_comb
    begin
        snap_next = clamped;
        for (int k = SnapCount - 1; k >= 0; k--)
        begin
            if (snap_hit[k])
            begin
                snap_next = DeltaW'(snap_point[k]);
            end
        end
    end

    // Replace the oldest ring entry in the running sum, carry the remainder
    assign sum_next     = sum_reg - SumW'(hist_reg[head_reg]) + SumW'(snap_reg);
    assign avg_total    = sum_next + SumW'(resid_reg);
    assign avg_next     = avg_total[SumW-1:HistIdxW];
    assign elapsed_next = elapsed_reg + TimeW'(avg_next);

    // Control state, configuration and ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= ResetPeriod;
            tol_reg       <= ResetTolerance;
            primed_reg    <= 1'b0;
            last_time_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            sum_reg       <= ResetSum;
            resid_reg     <= '0;
            elapsed_reg   <= '0;
            for (int i = 0; i < HistDepth; i++)
            begin
                hist_reg[i] <= DeltaW'(ResetPeriod);
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    RegTargetPeriod:  period_reg <= cfg_data;
                    RegSnapTolerance: tol_reg    <= cfg_data;
                    default:          ;
                endcase
            end

            // Take a timestamp; the first one only primes
            if (in_accept)
            begin
                last_time_reg <= now_us;
                primed_reg    <= 1'b1;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= in_accept && primed_reg;
            end

            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end

            // Commit the ring and totals as the result is registered
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s2_move)
            begin
                hist_reg[head_reg] <= snap_reg;
                head_reg           <= head_reg + HistIdxW'(1);
                sum_reg            <= sum_next;
                resid_reg          <= avg_total[HistIdxW-1:0];
                elapsed_reg        <= elapsed_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            diff_reg <= diff_next;
        end
        if (s1_move)
        begin
            snap_reg <= snap_next;
        end
        if (s2_move)
        begin
            smooth_reg <= avg_next;
        end
    end

    // Sum of ring entries, used only to check the running sum
    logic [SumW-1:0] hist_total;
    always_comb
    begin
        hist_total = '0;
        for (int i = 0; i < HistDepth; i++)
        begin
            hist_total = hist_total + SumW'(hist_reg[i]);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg == hist_total)
        else $error("running sum out of step with history ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> (!s1_valid_reg && !s2_valid_reg && !out_valid_reg))
        else $error("item in flight before first timestamp");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !primed_reg) |=> (primed_reg && !s1_valid_reg))
        else $error("priming timestamp produced an item");

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_move |=> (out_valid_reg && head_reg == $past(head_reg) + HistIdxW'(1)))
        else $error("ring head did not advance with result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(elapsed_reg))
        else $error("elapsed total moved while result held");

endmodule
